FILE: rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

	localparam int KEYWORD_MAX_LEN_DEF = 6;
	localparam int POSITION_WIDTH_DEF  = 16;
	localparam int OFFSET_WIDTH_DEF    = 32;

	localparam int LEN_W   = 16;
	localparam int TYPE_W  = 6;
	localparam int KW_NUM  = 9;
	localparam int KW_MAXC = 6;

	typedef enum logic [3:0] {
		M_IDLE,
		M_IDENT,
		M_INT,
		M_FRAC,
		M_EXP,
		M_EXPSIGN,
		M_EXPDIG,
		M_EQ,
		M_LT,
		M_GT,
		M_BANG
	} mode_t;

	localparam logic [TYPE_W-1:0] TOK_ID    = 6'd9;
	localparam logic [TYPE_W-1:0] TOK_NUM   = 6'd10;
	localparam logic [TYPE_W-1:0] TOK_FLOAT = 6'd11;
	localparam logic [TYPE_W-1:0] TOK_PLUS  = 6'd12;
	localparam logic [TYPE_W-1:0] TOK_MINUS = 6'd13;
	localparam logic [TYPE_W-1:0] TOK_STAR  = 6'd14;
	localparam logic [TYPE_W-1:0] TOK_SLASH = 6'd15;
	localparam logic [TYPE_W-1:0] TOK_LT    = 6'd16;
	localparam logic [TYPE_W-1:0] TOK_LE    = 6'd17;
	localparam logic [TYPE_W-1:0] TOK_EQ    = 6'd18;
	localparam logic [TYPE_W-1:0] TOK_GT    = 6'd19;
	localparam logic [TYPE_W-1:0] TOK_GE    = 6'd20;
	localparam logic [TYPE_W-1:0] TOK_NE    = 6'd21;
	localparam logic [TYPE_W-1:0] TOK_ASG   = 6'd22;
	localparam logic [TYPE_W-1:0] TOK_SEMI  = 6'd23;
	localparam logic [TYPE_W-1:0] TOK_LPAR  = 6'd24;
	localparam logic [TYPE_W-1:0] TOK_RPAR  = 6'd25;
	localparam logic [TYPE_W-1:0] TOK_LBRC  = 6'd26;
	localparam logic [TYPE_W-1:0] TOK_RBRC  = 6'd27;
	localparam logic [TYPE_W-1:0] TOK_LBRK  = 6'd28;
	localparam logic [TYPE_W-1:0] TOK_RBRK  = 6'd29;
	localparam logic [TYPE_W-1:0] TOK_COMMA = 6'd30;
	localparam logic [TYPE_W-1:0] TOK_END   = 6'd31;
	localparam logic [TYPE_W-1:0] TOK_UNK   = 6'd32;

	// keywords int, float, void, if, else, while, return, input, print
	localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAXC] = '{
		'{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74, 8'h00},
		'{8'h76, 8'h6f, 8'h69, 8'h64, 8'h00, 8'h00},
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
		'{8'h69, 8'h6e, 8'h70, 8'h75, 8'h74, 8'h00},
		'{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{
		3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd6, 3'd5, 3'd5
	};

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
	endfunction

	function automatic logic [TYPE_W-1:0] single_type(input logic [7:0] b);
		logic [TYPE_W-1:0] t;
		case (b)
			8'h2b:   t = TOK_PLUS;
			8'h2d:   t = TOK_MINUS;
			8'h2a:   t = TOK_STAR;
			8'h2f:   t = TOK_SLASH;
			8'h3b:   t = TOK_SEMI;
			8'h28:   t = TOK_LPAR;
			8'h29:   t = TOK_RPAR;
			8'h7b:   t = TOK_LBRC;
			8'h7d:   t = TOK_RBRC;
			8'h5b:   t = TOK_LBRK;
			8'h5d:   t = TOK_RBRK;
			8'h2c:   t = TOK_COMMA;
			default: t = TOK_UNK;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/c_like_lexer_tokenizer.sv
`timescale 1ns / 1ps
// Path: a byte's tokens go through the input register and then the result queue.
// Throughput: one byte per cycle unless stalled; the queue delivers one token per cycle
// while out_stall is low; a byte closing one token and emitting another fills two slots.
// Input stalls while the four-entry result queue has fewer than two free slots.
// Reset: asynchronous, clears scanner state, line to 1, column/offset to 0, queue empty.
module c_like_lexer_tokenizer
	import clt_pkg::*;
#(
	parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
	parameter int POSITION_WIDTH  = POSITION_WIDTH_DEF,
	parameter int OFFSET_WIDTH    = OFFSET_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                char_byte,
	input  logic                      end_of_input,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [TYPE_W-1:0]         token_type,
	output logic [POSITION_WIDTH-1:0] start_line,
	output logic [POSITION_WIDTH-1:0] start_column,
	output logic [OFFSET_WIDTH-1:0]   start_offset,
	output logic [LEN_W-1:0]          lexeme_length,
	output logic                      last_of_run
);

	localparam int PW    = POSITION_WIDTH;
	localparam int OW    = OFFSET_WIDTH;
	localparam int KIW   = $clog2(KEYWORD_MAX_LEN);
	localparam int QD    = 4;
	localparam int QAW   = 2;
	localparam logic [PW-1:0]    POS_MAX = '1;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef struct packed {
		logic [TYPE_W-1:0] ttype;
		logic [PW-1:0]     line;
		logic [PW-1:0]     col;
		logic [OW-1:0]     off;
		logic [LEN_W-1:0]  len;
		logic              last;
	} res_t;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// scanner state
	mode_t            mode_q, mode_d;
	logic [1:0]       flags_q, flags_d;
	logic [PW-1:0]    cur_line_q, cur_line_d, cur_col_q, cur_col_d;
	logic [PW-1:0]    tok_line_q, tok_line_d, tok_col_q, tok_col_d;
	logic [LEN_W-1:0] tok_len_q, tok_len_d;
	logic [OW-1:0]    tok_off_q, tok_off_d, byte_cnt_q, byte_cnt_d;
	logic [7:0]       kw_q [KEYWORD_MAX_LEN];
	logic             kw_we;
	logic [KIW-1:0]   kw_addr;

	// result queue
	res_t           que_q [QD];
	logic [QAW-1:0] rp_q, wp_q;
	logic [QAW:0]   cnt_q;

	logic       proc;
	logic       pop;
	logic       v0, v1;
	res_t       r0, r1, close_r;
	logic [TYPE_W-1:0] kw_type, pend_type;
	logic [PW-1:0]     col_inc, line_inc;
	logic [LEN_W-1:0]  len_inc;
	logic              is_end;

	assign proc     = v_s1 && (cnt_q <= (QAW+1)'(QD - 2));
	assign in_stall = v_s1 && !proc;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= char_byte;
			eoi_s1  <= end_of_input;
		end
	end

	always_comb begin
		logic hit;
		logic match;
		hit     = 1'b0;
		kw_type = TOK_ID;
		for (int k = 0; k < KW_NUM; k++) begin
			match = (tok_len_q == LEN_W'(KW_LEN[k]));
			for (int i = 0; i < KW_MAXC; i++) begin
				if (3'(i) < KW_LEN[k] && kw_q[i] != KW_TEXT[k][i])
					match = 1'b0;
			end
			if (match && !hit) begin
				hit     = 1'b1;
				kw_type = TYPE_W'(k);
			end
		end
	end

	always_comb begin
		unique case (mode_q)
			M_IDENT:  pend_type = kw_type;
			M_INT:    pend_type = TOK_NUM;
			M_FRAC:   pend_type = (flags_q != 2'b00) ? TOK_FLOAT : TOK_UNK;
			M_EXPDIG: pend_type = TOK_FLOAT;
			M_EQ:     pend_type = TOK_ASG;
			M_LT:     pend_type = TOK_LT;
			M_GT:     pend_type = TOK_GT;
			default:  pend_type = TOK_UNK;
		endcase
	end

	assign col_inc  = (cur_col_q == POS_MAX) ? POS_MAX : cur_col_q + PW'(1);
	assign line_inc = (cur_line_q == POS_MAX) ? POS_MAX : cur_line_q + PW'(1);
	assign len_inc  = (tok_len_q == LEN_MAX) ? LEN_MAX : tok_len_q + LEN_W'(1);
	assign is_end   = eoi_s1 || byte_s1 == 8'h00;

	always_comb begin
		logic  fed;
		logic  b_alpha, b_digit, b_e, b_eq;
		res_t  nr;
		mode_d     = mode_q;
		flags_d    = flags_q;
		cur_line_d = cur_line_q;
		cur_col_d  = cur_col_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		tok_len_d  = tok_len_q;
		tok_off_d  = tok_off_q;
		byte_cnt_d = byte_cnt_q;
		kw_we      = 1'b0;
		kw_addr    = '0;
		v0         = 1'b0;
		v1         = 1'b0;
		r0         = '0;
		r1         = '0;
		fed        = 1'b0;
		nr         = '0;
		b_alpha    = is_alpha(byte_s1);
		b_digit    = is_digit(byte_s1);
		b_e        = byte_s1 == 8'h65 || byte_s1 == 8'h45;
		b_eq       = byte_s1 == 8'h3d;

		close_r = '{ttype: pend_type, line: tok_line_q, col: tok_col_q,
			off: tok_off_q, len: tok_len_q, last: 1'b0};

		if (is_end) begin
			if (mode_q != M_IDLE) begin
				v0 = 1'b1;
				r0 = close_r;
				v1 = 1'b1;
				r1 = '{ttype: TOK_END, line: cur_line_q, col: col_inc,
					off: byte_cnt_q, len: '0, last: 1'b0};
			end else begin
				v0 = 1'b1;
				r0 = '{ttype: TOK_END, line: cur_line_q, col: col_inc,
					off: byte_cnt_q, len: '0, last: 1'b0};
			end
			mode_d  = M_IDLE;
			flags_d = 2'b00;
		end else begin
			if (byte_s1 == 8'h0a) begin
				cur_line_d = line_inc;
				cur_col_d  = '0;
			end else begin
				cur_col_d  = col_inc;
			end
			byte_cnt_d = byte_cnt_q + OW'(1);

			unique case (mode_q)
				M_IDENT: begin
					if (b_alpha || b_digit) begin
						fed       = 1'b1;
						tok_len_d = len_inc;
						if (tok_len_q < LEN_W'(KEYWORD_MAX_LEN)) begin
							kw_we   = 1'b1;
							kw_addr = tok_len_q[KIW-1:0];
						end
					end
				end
				M_INT: begin
					if (b_digit) begin
						fed = 1'b1;
					end else if (byte_s1 == 8'h2e) begin
						fed    = 1'b1;
						mode_d = M_FRAC;
					end else if (b_e) begin
						fed    = 1'b1;
						mode_d = M_EXP;
					end
					if (fed)
						tok_len_d = len_inc;
				end
				M_FRAC: begin
					if (b_digit) begin
						fed     = 1'b1;
						flags_d = flags_q | 2'b10;
					end else if (b_e) begin
						fed    = 1'b1;
						mode_d = M_EXP;
					end
					if (fed)
						tok_len_d = len_inc;
				end
				M_EXP: begin
					if (byte_s1 == 8'h2b || byte_s1 == 8'h2d) begin
						fed    = 1'b1;
						mode_d = M_EXPSIGN;
					end else if (b_digit) begin
						fed    = 1'b1;
						mode_d = M_EXPDIG;
					end
					if (fed)
						tok_len_d = len_inc;
				end
				M_EXPSIGN, M_EXPDIG: begin
					if (b_digit) begin
						fed       = 1'b1;
						mode_d    = M_EXPDIG;
						tok_len_d = len_inc;
					end
				end
				M_EQ, M_LT, M_GT, M_BANG: begin
					if (b_eq) begin
						fed     = 1'b1;
						v0      = 1'b1;
						r0      = close_r;
						r0.len  = LEN_W'(2);
						r0.ttype = (mode_q == M_EQ) ? TOK_EQ :
							(mode_q == M_LT) ? TOK_LE :
							(mode_q == M_GT) ? TOK_GE : TOK_NE;
						mode_d  = M_IDLE;
						flags_d = 2'b00;
					end
				end
				default: fed = 1'b0;
			endcase

			if (!fed) begin
				if (mode_q != M_IDLE) begin
					v0      = 1'b1;
					r0      = close_r;
					mode_d  = M_IDLE;
					flags_d = 2'b00;
				end
				if (!is_space(byte_s1)) begin
					tok_line_d = cur_line_q;
					tok_col_d  = col_inc;
					tok_off_d  = byte_cnt_q;
					tok_len_d  = LEN_W'(1);
					flags_d    = 2'b00;
					mode_d     = M_IDLE;
					if (b_alpha) begin
						mode_d  = M_IDENT;
						kw_we   = 1'b1;
						kw_addr = '0;
					end else if (b_digit) begin
						mode_d  = M_INT;
						flags_d = 2'b01;
					end else if (byte_s1 == 8'h2e) begin
						mode_d = M_FRAC;
					end else if (b_eq) begin
						mode_d = M_EQ;
					end else if (byte_s1 == 8'h3c) begin
						mode_d = M_LT;
					end else if (byte_s1 == 8'h3e) begin
						mode_d = M_GT;
					end else if (byte_s1 == 8'h21) begin
						mode_d = M_BANG;
					end else begin
						nr = '{ttype: single_type(byte_s1), line: cur_line_q, col: col_inc,
							off: byte_cnt_q, len: LEN_W'(1), last: 1'b0};
						if (v0) begin
							v1 = 1'b1;
							r1 = nr;
						end else begin
							v0 = 1'b1;
							r0 = nr;
						end
					end
				end
			end
		end

		r0.last = !v1;
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			flags_q    <= 2'b00;
			cur_line_q <= PW'(1);
			cur_col_q  <= '0;
			tok_line_q <= PW'(1);
			tok_col_q  <= '0;
			tok_len_q  <= '0;
			tok_off_q  <= '0;
			byte_cnt_q <= '0;
		end else if (proc) begin
			mode_q     <= mode_d;
			flags_q    <= flags_d;
			cur_line_q <= cur_line_d;
			cur_col_q  <= cur_col_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
			tok_len_q  <= tok_len_d;
			tok_off_q  <= tok_off_d;
			byte_cnt_q <= byte_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && kw_we)
			kw_q[kw_addr] <= byte_s1;
	end

	// result queue
	always_ff @(posedge clk) begin
		if (proc && v0)
			que_q[wp_q] <= r0;
		if (proc && v1)
			que_q[wp_q + QAW'(1)] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop)
				rp_q <= rp_q + QAW'(1);
			if (proc)
				wp_q <= wp_q + QAW'(v0) + QAW'(v1);
			cnt_q <= cnt_q + (proc ? (QAW+1)'(v0) + (QAW+1)'(v1) : '0) - (QAW+1)'(pop);
		end
	end

	assign out_valid     = cnt_q != '0;
	assign token_type    = que_q[rp_q].ttype;
	assign start_line    = que_q[rp_q].line;
	assign start_column  = que_q[rp_q].col;
	assign start_offset  = que_q[rp_q].off;
	assign lexeme_length = que_q[rp_q].len;
	assign last_of_run   = que_q[rp_q].last;

endmodule
